// File: rtl/core/etmm_pkg.sv
// ----------------------------------------------------------------------------
// etmm_pkg: shared constants, types and arithmetic helpers
// Holds the fixed-point formats, the CORDIC arctangent table and the
// rounding multiply that the model matrix datapath uses.
// ----------------------------------------------------------------------------
package etmm_pkg;

  // Angle resolution: 2^ANGLE_BITS is one full turn.
  localparam int ANGLE_BITS   = 16;
  localparam int CORDIC_STEPS = 30;
  // Working width of trigonometric values and rotation entries (Q2.30 plus headroom).
  localparam int VW           = 34;
  localparam logic signed [VW-1:0] CORDIC_GAIN = 34'sd652032874;

  // Pipeline depths of the two datapath parts.
  localparam int CORDIC_LAT = CORDIC_STEPS + 2;
  localparam int MERGE_LAT  = 5;
  localparam int CORE_LAT   = CORDIC_LAT + MERGE_LAT;

  localparam int IN_W  = 240;
  localparam int OUT_W = 384;

  typedef logic signed [VW-1:0] val_t;
  typedef logic signed [31:0]   fix_t;

  // Arctangent of 2^-i in units of 2^32 per turn.
  function automatic val_t atan_turn(input int idx);
    val_t r;
    case (idx)
      0:  r = 34'sd536870912;
      1:  r = 34'sd316933406;
      2:  r = 34'sd167458907;
      3:  r = 34'sd85004756;
      4:  r = 34'sd42667331;
      5:  r = 34'sd21354465;
      6:  r = 34'sd10679838;
      7:  r = 34'sd5340245;
      8:  r = 34'sd2670163;
      9:  r = 34'sd1335087;
      10: r = 34'sd667544;
      11: r = 34'sd333772;
      12: r = 34'sd166886;
      13: r = 34'sd83443;
      14: r = 34'sd41722;
      15: r = 34'sd20861;
      16: r = 34'sd10430;
      17: r = 34'sd5215;
      18: r = 34'sd2608;
      19: r = 34'sd1304;
      20: r = 34'sd652;
      21: r = 34'sd326;
      22: r = 34'sd163;
      23: r = 34'sd81;
      24: r = 34'sd41;
      25: r = 34'sd20;
      26: r = 34'sd10;
      27: r = 34'sd5;
      28: r = 34'sd3;
      29: r = 34'sd1;
      default: r = '0;
    endcase
    return r;
  endfunction

  // Q2.30 product rounded half up back to Q2.30.
  function automatic val_t mul_q30(input val_t a, input val_t b);
    logic signed [2*VW-1:0] p;
    p = (2*VW)'(a) * (2*VW)'(b) + ((2*VW)'(1) <<< 29);
    return VW'(p >>> 30);
  endfunction

endpackage

// File: rtl/core/etmm_cordic.sv
// ----------------------------------------------------------------------------
// etmm_cordic: one sine/cosine lane
// Fully pipelined rotation-mode CORDIC, one iteration per stage, followed
// by a quadrant correction stage.
// ----------------------------------------------------------------------------
module etmm_cordic (
  input  logic                           clk,
  input  logic                           en,
  input  logic [etmm_pkg::ANGLE_BITS-1:0] angle,
  output etmm_pkg::val_t                 cos_v,
  output etmm_pkg::val_t                 sin_v
);

  localparam int N = etmm_pkg::CORDIC_STEPS;

  logic [31:0]    turn;
  etmm_pkg::val_t x [0:N];
  etmm_pkg::val_t y [0:N];
  etmm_pkg::val_t z [0:N];
  logic [1:0]     quad [0:N];

  // Widen the angle to a 32 bit turn.
  assign turn = 32'(angle) << (32 - etmm_pkg::ANGLE_BITS);

  // Entry stage: seed the rotation with the gain-corrected unit vector.
  always_ff @(posedge clk) begin
    if (en) begin
      x[0]    <= etmm_pkg::CORDIC_GAIN;
      y[0]    <= '0;
      z[0]    <= etmm_pkg::VW'(turn[29:0]);
      quad[0] <= turn[31:30];
    end
  end

  // One micro-rotation per stage.
  for (genvar i = 0; i < N; i++) begin : g_iter
    always_ff @(posedge clk) begin
      if (en) begin
        quad[i+1] <= quad[i];
        if (!z[i][etmm_pkg::VW-1]) begin
          x[i+1] <= x[i] - (y[i] >>> i);
          y[i+1] <= y[i] + (x[i] >>> i);
          z[i+1] <= z[i] - etmm_pkg::atan_turn(i);
        end else begin
          x[i+1] <= x[i] + (y[i] >>> i);
          y[i+1] <= y[i] - (x[i] >>> i);
          z[i+1] <= z[i] + etmm_pkg::atan_turn(i);
        end
      end
    end
  end

  // Quadrant correction swaps and negates the result.
  always_ff @(posedge clk) begin
    if (en) begin
      case (quad[N])
        2'd0: begin cos_v <= x[N];  sin_v <= y[N];  end
        2'd1: begin cos_v <= -y[N]; sin_v <= x[N];  end
        2'd2: begin cos_v <= -x[N]; sin_v <= -y[N]; end
        default: begin cos_v <= y[N]; sin_v <= -x[N]; end
      endcase
    end
  end

endmodule

// File: rtl/core/etmm_merge.sv
// ----------------------------------------------------------------------------
// etmm_merge: rotation matrix assembly and scaling
// Combines the three lanes' sines and cosines into R = Ry*Rx*Rz, scales
// each column and saturates to Q16.16.
// ----------------------------------------------------------------------------
module etmm_merge (
  input  logic           clk,
  input  logic           en,
  input  etmm_pkg::val_t cx,
  input  etmm_pkg::val_t sx,
  input  etmm_pkg::val_t cy,
  input  etmm_pkg::val_t sy,
  input  etmm_pkg::val_t cz,
  input  etmm_pkg::val_t sz,
  input  etmm_pkg::fix_t sc [3],
  output etmm_pkg::fix_t ent [9]
);

  etmm_pkg::val_t sysx, cysx, cycz, cysz, sycz, sysz, cxsz, cxcz, sycx, cycx;
  etmm_pkg::val_t sz_a, cz_a, nsx_a;
  etmm_pkg::val_t b0, b1, b6, b7;
  etmm_pkg::val_t cycz_b, cysz_b, sycz_b, sysz_b, cxsz_b, cxcz_b, sycx_b, cycx_b, nsx_b;
  etmm_pkg::val_t r [9];
  etmm_pkg::fix_t sc_a [3];
  etmm_pkg::fix_t sc_b [3];
  etmm_pkg::fix_t sc_c [3];
  logic signed [65:0] prod [9];
  logic signed [35:0] rnd  [9];

  // First products of pairs of trigonometric values.
  always_ff @(posedge clk) begin
    if (en) begin
      sysx  <= etmm_pkg::mul_q30(sy, sx);
      cysx  <= etmm_pkg::mul_q30(cy, sx);
      cycz  <= etmm_pkg::mul_q30(cy, cz);
      cysz  <= etmm_pkg::mul_q30(cy, sz);
      sycz  <= etmm_pkg::mul_q30(sy, cz);
      sysz  <= etmm_pkg::mul_q30(sy, sz);
      cxsz  <= etmm_pkg::mul_q30(cx, sz);
      cxcz  <= etmm_pkg::mul_q30(cx, cz);
      sycx  <= etmm_pkg::mul_q30(sy, cx);
      cycx  <= etmm_pkg::mul_q30(cy, cx);
      sz_a  <= sz;
      cz_a  <= cz;
      nsx_a <= -sx;
      sc_a  <= sc;
    end
  end

  // Triple products formed from the rounded pairs.
  always_ff @(posedge clk) begin
    if (en) begin
      b0     <= etmm_pkg::mul_q30(sysx, sz_a);
      b1     <= etmm_pkg::mul_q30(sysx, cz_a);
      b6     <= etmm_pkg::mul_q30(cysx, sz_a);
      b7     <= etmm_pkg::mul_q30(cysx, cz_a);
      cycz_b <= cycz;
      cysz_b <= cysz;
      sycz_b <= sycz;
      sysz_b <= sysz;
      cxsz_b <= cxsz;
      cxcz_b <= cxcz;
      sycx_b <= sycx;
      cycx_b <= cycx;
      nsx_b  <= nsx_a;
      sc_b   <= sc_a;
    end
  end

  // Rotation entries.
  always_ff @(posedge clk) begin
    if (en) begin
      r[0] <= cycz_b + b0;
      r[1] <= b1 - cysz_b;
      r[2] <= sycx_b;
      r[3] <= cxsz_b;
      r[4] <= cxcz_b;
      r[5] <= nsx_b;
      r[6] <= b6 - sycz_b;
      r[7] <= sysz_b + b7;
      r[8] <= cycx_b;
      sc_c <= sc_b;
    end
  end

  // Column scaling, then rounding and saturation to the field range.
  for (genvar k = 0; k < 9; k++) begin : g_ent
    assign rnd[k] = 36'((prod[k] + 66'sd536870912) >>> 30);

    always_ff @(posedge clk) begin
      if (en) begin
        prod[k] <= 66'(r[k]) * 66'(sc_c[k % 3]);
        if (rnd[k] > 36'sd2147483647) begin
          ent[k] <= 32'sh7FFFFFFF;
        end else if (rnd[k] < -36'sd2147483648) begin
          ent[k] <= 32'sh80000000;
        end else begin
          ent[k] <= 32'(rnd[k]);
        end
      end
    end
  end

endmodule

// File: rtl/core/euler_trs_model_matrix_top.sv
// ----------------------------------------------------------------------------
// euler_trs_model_matrix_top: model matrix builder T*Ry*Rx*Rz*S
// Streaming block that turns position, Euler angles and scale into the
// upper three rows of the model matrix.
// ----------------------------------------------------------------------------
// Usage:
//   The slave channel (s_tvalid, s_tready, s_tdata) takes one word per object:
//   position, pitch/yaw/roll binary angles and per-axis scale. The master
//   channel (m_tvalid, m_tready, m_tdata) returns one word per input word
//   holding the twelve matrix entries in Q16.16, in input order.
//   Three CORDIC lanes work side by side on the three angles; a merging
//   pipeline builds, scales and saturates the rotation entries.
//   Throughput is one word per cycle while the output buffer is not held full.
//   The path from acceptance to m_tvalid runs through the CORDIC lanes (30 iterations
//   plus entry and quadrant stages), the merging pipeline and the output register.
//   Reset (rst, synchronous) empties the pipeline and the output buffer.
//   When the receiver stalls, a two-word output buffer keeps the pipeline
//   moving for one more word; only with both entries full and m_tready low
//   does s_tready fall and the whole pipeline hold.
// ----------------------------------------------------------------------------
module euler_trs_model_matrix_top (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_tvalid,
  output logic                       s_tready,
  // pos_x, pos_y, pos_z, pitch_angle, yaw_angle, roll_angle,
  // scale_x, scale_y, scale_z
  input  logic [etmm_pkg::IN_W-1:0]  s_tdata,
  output logic                       m_tvalid,
  input  logic                       m_tready,
  // m00, m01, m02, m03, m10, m11, m12, m13, m20, m21, m22, m23
  output logic [etmm_pkg::OUT_W-1:0] m_tdata
);

  localparam int L  = etmm_pkg::CORE_LAT;
  localparam int CL = etmm_pkg::CORDIC_LAT;
  localparam int OUT_LOCAL = etmm_pkg::OUT_W;

  logic                 en;
  logic [L-1:0]         vpipe;
  logic [95:0]          pos_dly [0:L-1];
  logic [95:0]          scl_dly [0:CL-1];
  etmm_pkg::val_t       cx, sx, cy, sy, cz, sz;
  etmm_pkg::fix_t       sc [3];
  etmm_pkg::fix_t       ent [9];
  logic [OUT_LOCAL-1:0] word;
  logic [etmm_pkg::OUT_W-1:0] out0, out1;
  logic [1:0]           cnt, cnt_next;
  logic                 push, pop;

  // The pipeline advances unless the output buffer is full and not draining.
  assign pop      = m_tvalid && m_tready;
  assign en       = (cnt != 2'd2) || m_tready;
  assign s_tready = en;
  assign push     = en && vpipe[L-1];

  // Valid bits travelling alongside the datapath.
  always_ff @(posedge clk) begin
    if (rst) begin
      vpipe <= '0;
    end else if (en) begin
      vpipe <= {vpipe[L-2:0], s_tvalid};
    end
  end

  // Delay lines for the translation and the scale factors.
  always_ff @(posedge clk) begin
    if (en) begin
      pos_dly[0] <= s_tdata[95:0];
      scl_dly[0] <= s_tdata[239:144];
      for (int i = 1; i < L; i++) begin
        pos_dly[i] <= pos_dly[i-1];
      end
      for (int i = 1; i < CL; i++) begin
        scl_dly[i] <= scl_dly[i-1];
      end
    end
  end

  // Sine and cosine lanes for pitch (x), yaw (y) and roll (z).
  etmm_cordic u_lane_x (
    .clk   (clk),
    .en    (en),
    .angle (s_tdata[96 +: etmm_pkg::ANGLE_BITS]),
    .cos_v (cx),
    .sin_v (sx)
  );

  etmm_cordic u_lane_y (
    .clk   (clk),
    .en    (en),
    .angle (s_tdata[112 +: etmm_pkg::ANGLE_BITS]),
    .cos_v (cy),
    .sin_v (sy)
  );

  etmm_cordic u_lane_z (
    .clk   (clk),
    .en    (en),
    .angle (s_tdata[128 +: etmm_pkg::ANGLE_BITS]),
    .cos_v (cz),
    .sin_v (sz)
  );

  assign sc[0] = scl_dly[CL-1][31:0];
  assign sc[1] = scl_dly[CL-1][63:32];
  assign sc[2] = scl_dly[CL-1][95:64];

  etmm_merge u_merge (
    .clk (clk),
    .en  (en),
    .cx  (cx),
    .sx  (sx),
    .cy  (cy),
    .sy  (sy),
    .cz  (cz),
    .sz  (sz),
    .sc  (sc),
    .ent (ent)
  );

  // Result word: three rotation-scale entries then the translation, per row.
  assign word = {pos_dly[L-1][95:64], ent[8], ent[7], ent[6],
                 pos_dly[L-1][63:32], ent[5], ent[4], ent[3],
                 pos_dly[L-1][31:0],  ent[2], ent[1], ent[0]};

  // Two-entry output buffer; out0 is the head shown on the master side.
  assign cnt_next = cnt + 2'(push) - 2'(pop);

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else begin
      cnt <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push && (cnt == 2'd0 || (cnt == 2'd1 && pop))) begin
      out0 <= word;
    end else if (pop && cnt == 2'd2) begin
      out0 <= out1;
    end
    if (push && ((cnt == 2'd1 && !pop) || (cnt == 2'd2 && pop))) begin
      out1 <= word;
    end
  end

  assign m_tvalid = (cnt != 2'd0);
  assign m_tdata  = out0;

  // The buffer never holds more than two words.
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst) cnt != 2'd3)
    else $error("output buffer overflow");

  // A held pipeline keeps its valid bits.
  a_hold: assert property (@(posedge clk) disable iff (rst) !en |=> $stable(vpipe))
    else $error("pipeline moved while held");

  // A full, stalled buffer stops the input side.
  a_full_stall: assert property (@(posedge clk) disable iff (rst)
    (cnt == 2'd2 && !m_tready) |-> !s_tready)
    else $error("input accepted with full output buffer");

  // A word leaving the pipeline is never dropped.
  a_no_drop: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> (cnt != 2'd0))
    else $error("result word lost");

endmodule

// File: dv/etmm_checker.sv
// ----------------------------------------------------------------------------
// etmm_checker: predictor and scoreboard for the model matrix builder
// Watches both stream channels, computes the expected matrix for every
// accepted input word and compares each output word field by field.
// ----------------------------------------------------------------------------
module etmm_checker (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_tvalid,
  input  logic                       s_tready,
  input  logic [etmm_pkg::IN_W-1:0]  s_tdata,
  input  logic                       m_tvalid,
  input  logic                       m_tready,
  input  logic [etmm_pkg::OUT_W-1:0] m_tdata,
  output int                         fail_count,
  output int                         pending
);

  localparam longint ATAN_TAB [30] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
    41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
    10, 5, 3, 1};

  logic [etmm_pkg::OUT_W-1:0] matrix_q[$];
  int               words_out;

  assign pending = matrix_q.size();

  // Round half up from Q(2+30) products back to the lower format.
  function automatic longint rmul(longint a, longint b);
    return (a * b + (64'sd1 <<< 29)) >>> 30;
  endfunction

  // Quadrant split followed by a floor-shift CORDIC rotation.
  function automatic void trig(input logic [15:0] ang, output longint c,
                               output longint s);
    logic [31:0] turn;
    longint x, y, z, nx;
    turn = {ang, 16'h0};
    z = longint'(turn[29:0]);
    x = 652032874;
    y = 0;
    for (int i = 0; i < 30; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y  = y + (x >>> i);
        z  = z - ATAN_TAB[i];
      end else begin
        nx = x + (y >>> i);
        y  = y - (x >>> i);
        z  = z + ATAN_TAB[i];
      end
      x = nx;
    end
    case (turn[31:30])
      2'd0: begin c = x;  s = y;  end
      2'd1: begin c = -y; s = x;  end
      2'd2: begin c = -x; s = -y; end
      default: begin c = y; s = -x; end
    endcase
  endfunction

  function automatic logic [31:0] sat_entry(longint r, logic signed [31:0] sc);
    longint v;
    v = rmul(r, longint'(sc));
    if (v > 64'sd2147483647) v = 64'sd2147483647;
    if (v < -64'sd2147483648) v = -64'sd2147483648;
    return v[31:0];
  endfunction

  // Builds the twelve output fields for one object.
  function automatic logic [etmm_pkg::OUT_W-1:0] model_matrix(
      logic [etmm_pkg::IN_W-1:0] w);
    longint cx, sx, cy, sy, cz, sz, sysx, cysx;
    longint r[9];
    logic [etmm_pkg::OUT_W-1:0] m;
    trig(w[111:96], cx, sx);
    trig(w[127:112], cy, sy);
    trig(w[143:128], cz, sz);
    sysx = rmul(sy, sx);
    cysx = rmul(cy, sx);
    r[0] = rmul(cy, cz) + rmul(sysx, sz);
    r[1] = rmul(sysx, cz) - rmul(cy, sz);
    r[2] = rmul(sy, cx);
    r[3] = rmul(cx, sz);
    r[4] = rmul(cx, cz);
    r[5] = -sx;
    r[6] = rmul(cysx, sz) - rmul(sy, cz);
    r[7] = rmul(sy, sz) + rmul(cysx, cz);
    r[8] = rmul(cy, cx);
    for (int k = 0; k < 3; k++) begin
      for (int j = 0; j < 3; j++)
        m[(k*4+j)*32 +: 32] = sat_entry(r[k*3+j], w[144+j*32 +: 32]);
      m[(k*4+3)*32 +: 32] = w[k*32 +: 32];
    end
    return m;
  endfunction

  // Predict on input words, compare on output words.
  always @(posedge clk) begin
    logic [etmm_pkg::OUT_W-1:0] exp_m;
    if (rst) begin
      fail_count <= 0;
      words_out  <= 0;
    end else begin
      if (s_tvalid && s_tready) matrix_q.push_back(model_matrix(s_tdata));
      if (m_tvalid && m_tready) begin
        words_out <= words_out + 1;
        if (matrix_q.size() == 0) begin
          $display("%0t: unexpected output word %h", $time, m_tdata);
          fail_count <= fail_count + 1;
        end else begin
          exp_m = matrix_q.pop_front();
          for (int f = 0; f < 12; f++)
            if (exp_m[f*32 +: 32] !== m_tdata[f*32 +: 32])
              $display("%0t: word %0d m%0d%0d expected %h actual %h", $time,
                       words_out, f / 4, f % 4, exp_m[f*32 +: 32],
                       m_tdata[f*32 +: 32]);
          if (exp_m !== m_tdata) fail_count <= fail_count + 1;
        end
      end
    end
  end
endmodule

// File: dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: stimulus and verdict for the model matrix builder
// Drives directed and random objects with random gaps and stalls, lets the
// checker score every output word, and reports the result.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int N_RANDOM  = 400;
  localparam int WDOG_MAX  = 2000;

  logic             clk;
  logic             rst;
  logic             s_tvalid;
  logic             s_tready;
  logic [etmm_pkg::IN_W-1:0]  s_tdata;
  logic             m_tvalid;
  logic             m_tready;
  logic [etmm_pkg::OUT_W-1:0] m_tdata;
  int               fail_count;
  int               pending;
  int               idle_cycles;
  int               words_in;
  bit               hold_sink;
  bit               send_done;

  euler_trs_model_matrix_top dut (.*);

  etmm_checker u_chk (.*);

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Random 32 bit value weighted towards corners and small scales.
  function automatic logic [31:0] pick32();
    case ($urandom_range(0, 7))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'(signed'($urandom_range(0, 8 << 16)) - (4 << 16));
      3: return 32'h0001_0000;
      default: return $urandom();
    endcase
  endfunction

  // Offers one word and holds it until taken.
  task automatic send_word(logic [etmm_pkg::IN_W-1:0] w);
    repeat ($urandom_range(0, 17)) @(negedge clk);
    s_tdata  <= w;
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    words_in++;
    @(negedge clk);
    s_tvalid <= 1'b0;
  endtask

  function automatic logic [etmm_pkg::IN_W-1:0] object_word(logic [31:0] p[3],
      logic [15:0] a[3], logic [31:0] sc[3]);
    return {sc[2], sc[1], sc[0], a[2], a[1], a[0], p[2], p[1], p[0]};
  endfunction

  // Receiver: a random wait before each word, or a long hold-off when asked.
  initial begin
    m_tready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_sink) begin
        m_tready <= 1'b0;
        repeat (150) @(negedge clk);
        hold_sink = 1'b0;
      end
      m_tready <= 1'b0;
      repeat ($urandom_range(0, 17)) @(negedge clk);
      m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
      @(negedge clk);
    end
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WDOG_MAX) begin
      $display("euler_trs_model_matrix_top verification failed");
      $finish;
    end
  end

  initial begin
    logic [31:0] p[3];
    logic [15:0] a[3];
    logic [31:0] sc[3];
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    hold_sink = 1'b0;
    send_done = 1'b0;
    words_in = 0;
    repeat (12) @(negedge clk);
    rst = 1'b0;

    // Directed objects: angle quadrants, extreme and negative scales.
    for (int d = 0; d < 20; d++) begin
      p  = '{32'h7FFF_FFFF, 32'h8000_0000, 32'(d) << 16};
      a  = '{16'(d * 16'h2000), 16'(16'hFFFF - d * 16'h1000), 16'(d * 16'h0C00)};
      sc = '{32'h0001_0000, 32'hFFFF_0000, 32'h0001_0000};
      if (d >= 8)  sc = '{32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF};
      if (d >= 14) sc = '{32'h0, 32'h4000_0000, 32'hC000_0000};
      if (d == 19) a = '{16'hFFFF, 16'h0, 16'h8000};
      send_word(object_word(p, a, sc));
    end

    // Pause until every expected word has come out.
    while (pending != 0) @(negedge clk);

    for (int n = 0; n < N_RANDOM; n++) begin
      // Fill the pipeline against a stalled receiver once.
      if (n == 150) hold_sink = 1'b1;
      for (int k = 0; k < 3; k++) begin
        p[k]  = pick32();
        a[k]  = $urandom();
        sc[k] = pick32();
      end
      if (n >= 150 && n < 200) begin
        s_tdata  <= object_word(p, a, sc);
        s_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        words_in++;
        @(negedge clk);
        if (n == 199) s_tvalid <= 1'b0;
      end else if (n % 60 < 10) begin
        s_tdata  <= object_word(p, a, sc);
        s_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        words_in++;
        @(negedge clk);
        if (n % 60 == 9) s_tvalid <= 1'b0;
      end else
        send_word(object_word(p, a, sc));
    end
    s_tvalid <= 1'b0;
    send_done = 1'b1;

    while (pending != 0) @(negedge clk);
    repeat (60) @(negedge clk);
    $display("Sent %0d objects: quadrant angles, corner positions, extreme and", words_in);
    $display("negative scales, with random gaps, stalls and one long back-pressure hold.");
    if (fail_count == 0 && pending == 0)
      $display("euler_trs_model_matrix_top verification clean");
    else
      $display("euler_trs_model_matrix_top verification failed");
    $finish;
  end
endmodule
